/* src/lftl_pkg.sv */
// Shared types and constants for the looping frame time lookup unit.
package lftl_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 11;
    localparam int STATUS_W   = 2;
    localparam int MAX_FRAMES = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZDUR  = 2'd2;

    typedef struct packed {
        logic              op;
        logic [9:0]        idx;
        logic [TIME_W-1:0] etime;
        logic [TIME_W-1:0] qtime;
    } t_cmd;

endpackage

/* src/lftl_front.sv */
// Front end: accepts input words into a two-entry queue for the back end.
module lftl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  lftl_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_take,
    output lftl_pkg::t_cmd  o_cmd
);
    lftl_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* src/lftl_back.sv */
// Back end: table memory, serial division, two binary searches and loop offset.
module lftl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_take,
    input  lftl_pkg::t_cmd                    i_cmd,
    input  logic [lftl_pkg::CFG_W-1:0]        i_frame_count,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lftl_pkg::TIME_W-1:0]       o_floor_frame,
    output logic [lftl_pkg::TIME_W-1:0]       o_ceil_frame,
    output logic [lftl_pkg::STATUS_W-1:0]     o_lookup_status
);
    localparam int AW = $clog2(lftl_pkg::MAX_FRAMES);
    localparam int NW = $clog2(lftl_pkg::MAX_FRAMES + 1);
    localparam int TW = lftl_pkg::TIME_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDF, S_RDL, S_CHK, S_DIV, S_SRD, S_SCMP, S_MUL, S_OUT
    } t_state;

    t_state          r_state;
    logic [TW-1:0]   r_mem [lftl_pkg::MAX_FRAMES];
    logic [TW-1:0]   r_rdata;
    logic [AW-1:0]   r_raddr;
    logic [NW-1:0]   r_n;
    logic [TW-1:0]   r_first, r_t, r_dur, r_quo, r_rem, r_cyc;
    logic [5:0]      r_bit;
    logic            r_strict;
    logic [NW-1:0]   r_lo, r_cnt, r_step, r_ub;
    logic [TW-1:0]   r_base;
    logic [TW-1:0]   r_fl, r_ce;
    logic [lftl_pkg::STATUS_W-1:0] r_st;
    logic            r_ov;
    logic [NW-1:0]   nclamp, lb_fin, probe;
    logic [TW:0]     rem_sh;
    logic            go_r;

    always_comb begin
        if (i_frame_count > NW'(lftl_pkg::MAX_FRAMES)) nclamp = NW'(lftl_pkg::MAX_FRAMES);
        else nclamp = i_frame_count[NW-1:0];
        rem_sh = {r_rem, r_t[TW-1]};
        probe  = r_lo + r_step;
        go_r   = r_strict ? (r_rdata <= r_cyc) : (r_rdata < r_cyc);
        lb_fin = r_lo;
    end

    assign o_take          = (r_state == S_IDLE) && !r_ov;
    assign o_valid         = r_ov;
    assign o_floor_frame   = r_fl;
    assign o_ceil_frame    = r_ce;
    assign o_lookup_status = r_st;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_raddr];
        if (o_take && i_valid && i_cmd.op == lftl_pkg::OP_WRITE) begin
            r_mem[i_cmd.idx] <= i_cmd.etime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_take && i_valid && i_cmd.op == lftl_pkg::OP_QUERY) begin
                        r_n     <= nclamp;
                        r_t     <= i_cmd.qtime;
                        r_raddr <= '0;
                        if (nclamp == '0) begin
                            r_fl    <= '0;
                            r_ce    <= '0;
                            r_st    <= lftl_pkg::ST_EMPTY;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RDF;
                        end
                    end
                end
                S_RDF: begin
                    r_raddr <= AW'(r_n - 1'b1);
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    r_first <= r_rdata;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_rdata <= r_first) begin
                        r_fl    <= '0;
                        r_ce    <= '0;
                        r_st    <= lftl_pkg::ST_ZDUR;
                        r_state <= S_OUT;
                    end else begin
                        r_dur   <= r_rdata - r_first;
                        r_rem   <= '0;
                        r_bit   <= 6'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_t <= {r_t[TW-2:0], 1'b0};
                    if (rem_sh >= {1'b0, r_dur}) begin
                        r_rem <= TW'(rem_sh - {1'b0, r_dur});
                        r_quo <= {r_quo[TW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[TW-1:0];
                        r_quo <= {r_quo[TW-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 6'(TW - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_rem == '0 && r_quo != '0) begin
                        r_cyc <= r_dur;
                        r_quo <= r_quo - 1'b1;
                    end else begin
                        r_cyc <= r_rem;
                    end
                    r_strict <= 1'b1;
                    r_lo     <= '0;
                    r_cnt    <= r_n;
                    r_state  <= S_SRD;
                end
                S_SRD: begin
                    r_base <= TW'(64'(r_quo) * 64'(r_n));
                    if (r_cnt == '0) begin
                        if (r_strict) begin
                            r_ub     <= lb_fin;
                            r_strict <= 1'b0;
                            r_lo     <= '0;
                            r_cnt    <= r_n;
                        end else begin
                            if (r_ub == '0) r_fl <= r_base;
                            else if (r_ub >= r_n) r_fl <= r_base + TW'(r_n - 1'b1);
                            else r_fl <= r_base + TW'(r_ub - 1'b1);
                            if (lb_fin >= r_n) r_ce <= r_base + TW'(r_n - 1'b1);
                            else r_ce <= r_base + TW'(lb_fin);
                            r_st    <= lftl_pkg::ST_OK;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_step  <= r_cnt >> 1;
                        r_raddr <= AW'(r_lo + (r_cnt >> 1));
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (r_bit[0]) begin
                        if (go_r) begin
                            r_lo  <= probe + 1'b1;
                            r_cnt <= r_cnt - r_step - 1'b1;
                        end else begin
                            r_cnt <= r_step;
                        end
                        r_bit   <= 6'd0;
                        r_state <= S_SRD;
                    end else begin
                        r_bit <= 6'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/looping_frame_time_lookup_unit.sv */
// Top level of the looping frame time lookup unit.
//
//  channel  direction  handshake        word
//  in       input      valid / stall    operation, entry_index, entry_time, query_time
//  out      output     valid / stall    floor_frame, ceil_frame, lookup_status
//  cfg      input      valid / ready    frame_count
//
// A write goes into the table when the back end takes it in its idle state. A query reads
// the first and last entries, checks for zero duration, divides bit-serially, then runs two
// binary searches; each step sets a probe address, then compares the entry read there.
// Reset clears the queue, the result valid flag and frame_count; the table is not cleared.
// A waiting result holds the back end; the front queue keeps accepting until it holds two words.
module looping_frame_time_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [9:0]  i_entry_index,
    input  logic [31:0] i_entry_time,
    input  logic [31:0] i_query_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_floor_frame,
    output logic [31:0] o_ceil_frame,
    output logic [1:0]  o_lookup_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    lftl_pkg::t_cmd in_cmd, q_cmd;
    logic           q_valid, q_take;
    logic [10:0]    r_frame_count;

    assign in_cmd.op    = i_operation;
    assign in_cmd.idx   = i_entry_index;
    assign in_cmd.etime = i_entry_time;
    assign in_cmd.qtime = i_query_time;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
        end else if (i_cfg_valid) begin
            r_frame_count <= i_cfg_data;
        end
    end

    lftl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (in_cmd),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_cmd   (q_cmd)
    );

    lftl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_take          (q_take),
        .i_cmd           (q_cmd),
        .i_frame_count   (r_frame_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_floor_frame   (o_floor_frame),
        .o_ceil_frame    (o_ceil_frame),
        .o_lookup_status (o_lookup_status)
    );
endmodule
